@@ src/dgrs_pkg.sv @@
// Shared types and constants for the declick gain ramp stage.
`default_nettype none
package dgrs_pkg;

   localparam int CHANNELS_DEF    = 2;
   localparam int SAMPLE_BITS_DEF = 24;

   // Gains are unsigned Q1.30, steps signed Q1.30 in 32 bits.
   localparam int GAIN_BITS  = 31;
   localparam int GAIN_SHIFT = 30;
   localparam int STEP_BITS  = 32;
   localparam int LEN_BITS   = 16;
   localparam int DIV_CNT_BITS = $clog2(GAIN_BITS);

   localparam logic [GAIN_BITS-1:0] GAIN_ONE  = GAIN_BITS'(1) << GAIN_SHIFT;
   localparam logic [GAIN_BITS-1:0] GAIN_ZERO = '0;

   // Configuration registers.
   localparam int CSR_IDX_BITS = 1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_START_STOP_LEN = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MUTE_LEN       = 1'd1;
   localparam logic [LEN_BITS-1:0] START_STOP_LEN_RST = 16'd480;
   localparam logic [LEN_BITS-1:0] MUTE_LEN_RST       = 16'd240;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_DIV   = 6'b000010,
      S_ADV   = 6'b000100,
      S_MUL   = 6'b001000,
      S_SCALE = 6'b010000,
      S_OUT   = 6'b100000
   } state_type;

   // Sequencer to ramp unit.
   typedef struct packed {
      logic                start;
      logic                goal;
      logic [LEN_BITS-1:0] len;
      logic                advance;
   } ramp_ctrl_type;

   // Ramp unit back to sequencer.
   typedef struct packed {
      logic [GAIN_BITS-1:0] gain;
      logic                 left_zero;
      logic                 busy;
   } ramp_stat_type;

endpackage
`default_nettype wire

@@ src/dgrs_if.sv @@
// Request and response channel interfaces.
`default_nettype none
interface dgrs_req_if #(
   parameter int CHANNELS    = 2,
   parameter int SAMPLE_BITS = 24
);
   logic                                  valid;
   logic                                  ready;
   logic                                  first_of_block;
   logic                                  run_request;
   logic                                  mute_request;
   logic [CHANNELS-1:0][SAMPLE_BITS-1:0]  sample_in;

   modport source (output valid, first_of_block, run_request, mute_request, sample_in,
                   input ready);
   modport sink   (input valid, first_of_block, run_request, mute_request, sample_in,
                   output ready);
endinterface

interface dgrs_rsp_if #(
   parameter int CHANNELS    = 2,
   parameter int SAMPLE_BITS = 24
);
   logic                                  valid;
   logic                                  ready;
   logic [CHANNELS-1:0][SAMPLE_BITS-1:0]  sample_out;
   logic                                  transport_silent;

   modport source (output valid, sample_out, transport_silent, input ready);
   modport sink   (input valid, sample_out, transport_silent, output ready);
endinterface
`default_nettype wire

@@ src/dgrs_div.sv @@
// Bit-serial restoring divider for ramp step magnitudes.
`default_nettype none
module dgrs_div
   import dgrs_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [GAIN_BITS-1:0] dividend,
   input  wire logic [LEN_BITS-1:0]  divisor,
   output      logic                 busy,
   output      logic                 done,
   output      logic [GAIN_BITS-1:0] quotient
);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [GAIN_BITS-1:0]    quot_ff, quot_in;
   logic [LEN_BITS-1:0]     dvs_ff, dvs_in;
   logic [LEN_BITS-1:0]     rem_ff, rem_in;
   logic [LEN_BITS:0]       shifted;
   logic [LEN_BITS:0]       diff;
   logic                    ge;

   assign shifted = {rem_ff, quot_ff[GAIN_BITS-1]};
   assign ge      = shifted >= {1'b0, dvs_ff};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quot_in = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[LEN_BITS-1:0] : shifted[LEN_BITS-1:0];
         quot_in = {quot_ff[GAIN_BITS-2:0], ge};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_BITS'(GAIN_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      dvs_ff  <= dvs_in;
      rem_ff  <= rem_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule
`default_nettype wire

@@ src/dgrs_ramp.sv @@
// One linear gain ramp: gain, step, frames left and target, with its step divider.
`default_nettype none
module dgrs_ramp
   import dgrs_pkg::*;
#(
   parameter logic RESET_GOAL = 1'b0
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire ramp_ctrl_type ctrl,
   output      ramp_stat_type stat
);

   logic [GAIN_BITS-1:0] gain_ff, gain_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic [LEN_BITS-1:0]  left_ff, left_in;
   logic                 goal_ff, goal_in;
   logic                 neg_ff, neg_in;

   logic [GAIN_BITS-1:0] div_dividend;
   logic [LEN_BITS-1:0]  div_divisor;
   logic                 div_busy;
   logic                 div_done;
   logic [GAIN_BITS-1:0] div_quot;

   logic signed [STEP_BITS:0] sum;
   logic [LEN_BITS-1:0]       left_dec;

   // Distance to the target, as magnitude plus sign; zero length counts as one.
   assign div_dividend = ctrl.goal ? (GAIN_ONE - gain_ff) : gain_ff;
   assign div_divisor  = (ctrl.len == '0) ? LEN_BITS'(1) : ctrl.len;

   dgrs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (ctrl.start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign sum      = $signed({2'b00, gain_ff}) + $signed({step_ff[STEP_BITS-1], step_ff});
   assign left_dec = left_ff - 1'b1;

   always_comb begin
      gain_in = gain_ff;
      step_in = step_ff;
      left_in = left_ff;
      goal_in = goal_ff;
      neg_in  = neg_ff;
      if (ctrl.start) begin
         goal_in = ctrl.goal;
         left_in = div_divisor;
         neg_in  = !ctrl.goal;
      end
      if (div_done) begin
         step_in = neg_ff ? (STEP_BITS'(0) - {1'b0, div_quot}) : {1'b0, div_quot};
      end
      if (ctrl.advance && left_ff != '0) begin
         left_in = left_dec;
         if (left_dec == '0) begin
            gain_in = goal_ff ? GAIN_ONE : GAIN_ZERO;
         end else if (sum < 0) begin
            gain_in = GAIN_ZERO;
         end else if (sum > $signed({2'b00, GAIN_ONE})) begin
            gain_in = GAIN_ONE;
         end else begin
            gain_in = sum[GAIN_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= RESET_GOAL ? GAIN_ONE : GAIN_ZERO;
         step_ff <= '0;
         left_ff <= '0;
         goal_ff <= RESET_GOAL;
         neg_ff  <= 1'b0;
      end else begin
         gain_ff <= gain_in;
         step_ff <= step_in;
         left_ff <= left_in;
         goal_ff <= goal_in;
         neg_ff  <= neg_in;
      end
   end

   assign stat.gain      = gain_ff;
   assign stat.left_zero = (left_ff == '0);
   assign stat.busy      = div_busy;

endmodule
`default_nettype wire

@@ src/dgrs_lane.sv @@
// One channel lane: sample times combined gain, floored back to sample width.
`default_nettype none
module dgrs_lane
   import dgrs_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   load,
   input  wire logic [SAMPLE_BITS-1:0] sample,
   input  wire logic [GAIN_BITS-1:0]   gain,
   output      logic [SAMPLE_BITS-1:0] result
);

   localparam int PROD_BITS = SAMPLE_BITS + GAIN_BITS + 1;

   logic signed [PROD_BITS-1:0] prod_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= PROD_BITS'($signed(sample) * $signed({1'b0, gain}));
      end
   end

   // Arithmetic shift of the product floors toward minus infinity.
   assign result = prod_ff[GAIN_SHIFT +: SAMPLE_BITS];

endmodule
`default_nettype wire

@@ src/declick_gain_ramp_stage.sv @@
// Top level of the declick gain ramp stage.
`default_nettype none
// Declick gain ramp stage. Each request carries one multichannel frame plus run
// and mute requests; the response carries every channel scaled by the product
// of a transport gain ramp (0 stopped, 1 running) and a mute ramp (1 unmuted,
// 0 muted), and a silent flag. Requests are only looked at on a frame marked
// first of block; a change starts a linear ramp over the configured number of
// frames (csr index 0: start/stop length, index 1: mute length; 0 acts as 1).
// Gains are unsigned Q1.30, outputs are floored. One request is in flight at a
// time: a frame steps through the advance, multiply, scale and output states,
// and a frame that starts a ramp first waits in the divide state, since the
// step is found by a bit-serial divider that retires one quotient bit per cycle
// (both ramps divide in parallel). The response sits in an output register, so
// the next request is accepted while the previous response still waits.
module declick_gain_ramp_stage
   import dgrs_pkg::*;
#(
   parameter int CHANNELS    = CHANNELS_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_we,
   input  wire logic [CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [LEN_BITS-1:0]     csr_wdata,
   dgrs_req_if.sink                     req_ch,
   dgrs_rsp_if.source                   rsp_ch
);

   state_type state_ff, state_in;

   logic [LEN_BITS-1:0] ss_len_ff, ss_len_in;
   logic [LEN_BITS-1:0] mute_len_ff, mute_len_in;

   logic running_ff, running_in;
   logic muted_ff, muted_in;
   logic silent_ff, silent_in;

   logic [CHANNELS-1:0][SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic [GAIN_BITS-1:0]                 gain_ff, gain_in;
   logic [CHANNELS-1:0][SAMPLE_BITS-1:0] lane_out;

   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [CHANNELS-1:0][SAMPLE_BITS-1:0] rsp_sample_ff, rsp_sample_in;
   logic                                 rsp_silent_ff, rsp_silent_in;

   logic accept;
   logic t_start, m_start;
   logic rsp_free;
   logic [2*GAIN_BITS-1:0] gain_prod;

   ramp_ctrl_type t_ctrl, m_ctrl;
   ramp_stat_type t_stat, m_stat;

   assign accept   = req_ch.valid && req_ch.ready;
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;

   // A changed request on a block boundary restarts that ramp from its current gain.
   assign t_start = accept && req_ch.first_of_block && (req_ch.run_request != running_ff);
   assign m_start = accept && req_ch.first_of_block && (req_ch.mute_request != muted_ff);

   assign t_ctrl.start   = t_start;
   assign t_ctrl.goal    = req_ch.run_request;
   assign t_ctrl.len     = ss_len_ff;
   assign t_ctrl.advance = (state_ff == S_ADV);

   assign m_ctrl.start   = m_start;
   assign m_ctrl.goal    = !req_ch.mute_request;
   assign m_ctrl.len     = mute_len_ff;
   assign m_ctrl.advance = (state_ff == S_ADV);

   dgrs_ramp #(.RESET_GOAL(1'b0)) u_transport (
      .clock (clock),
      .reset (reset),
      .ctrl  (t_ctrl),
      .stat  (t_stat)
   );

   dgrs_ramp #(.RESET_GOAL(1'b1)) u_mute (
      .clock (clock),
      .reset (reset),
      .ctrl  (m_ctrl),
      .stat  (m_stat)
   );

   // Combined gain, Q1.30 times Q1.30 back to Q1.30, truncated.
   assign gain_prod = t_stat.gain * m_stat.gain;

   for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
      dgrs_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane (
         .clock  (clock),
         .load   (state_ff == S_SCALE),
         .sample (sample_ff[ch]),
         .gain   (gain_ff),
         .result (lane_out[ch])
      );
   end

   assign req_ch.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in      = state_ff;
      ss_len_in     = ss_len_ff;
      mute_len_in   = mute_len_ff;
      running_in    = running_ff;
      muted_in      = muted_ff;
      silent_in     = silent_ff;
      sample_in     = sample_ff;
      gain_in       = gain_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_silent_in = rsp_silent_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_START_STOP_LEN: ss_len_in   = csr_wdata;
            CSR_MUTE_LEN:       mute_len_in = csr_wdata;
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               sample_in = req_ch.sample_in;
               if (t_start) begin
                  running_in = req_ch.run_request;
                  if (req_ch.run_request) begin
                     silent_in = 1'b0;
                  end
               end
               if (m_start) begin
                  muted_in = req_ch.mute_request;
               end
               state_in = (t_start || m_start) ? S_DIV : S_ADV;
            end
         end
         S_DIV: begin
            // Steps are latched by the ramps as their dividers finish.
            if (!t_stat.busy && !m_stat.busy) begin
               state_in = S_ADV;
            end
         end
         S_ADV: begin
            state_in = S_MUL;
         end
         S_MUL: begin
            gain_in = gain_prod[GAIN_SHIFT +: GAIN_BITS];
            // Silent is checked on every frame, after the gains advanced.
            if (!running_ff && t_stat.left_zero && t_stat.gain == GAIN_ZERO) begin
               silent_in = 1'b1;
            end
            state_in = S_SCALE;
         end
         S_SCALE: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = lane_out;
               rsp_silent_in = silent_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ss_len_ff    <= START_STOP_LEN_RST;
         mute_len_ff  <= MUTE_LEN_RST;
         running_ff   <= 1'b0;
         muted_ff     <= 1'b0;
         silent_ff    <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ss_len_ff    <= ss_len_in;
         mute_len_ff  <= mute_len_in;
         running_ff   <= running_in;
         muted_ff     <= muted_in;
         silent_ff    <= silent_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff     <= sample_in;
      gain_ff       <= gain_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_silent_ff <= rsp_silent_in;
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.sample_out       = rsp_sample_ff;
   assign rsp_ch.transport_silent = rsp_silent_ff;

endmodule
`default_nettype wire
